@@ hw/rtl/mbag_pkg.sv @@
`timescale 1ns / 1ps
// Package for the bag table: sizes, field widths and command codes.
package mbag_pkg;

	localparam int BAG_DEPTH = 1024;
	localparam int ADDR_W    = (BAG_DEPTH > 1) ? $clog2(BAG_DEPTH) : 1;
	localparam int OCC_W     = $clog2(BAG_DEPTH + 1);
	localparam int VALUE_W   = 32;
	localparam int COUNT_W   = 11;
	localparam int CMD_W     = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT    = 2'd0,
		CMD_ERASE_ONE = 2'd1,
		CMD_ERASE_ALL = 2'd2
	} cmd_t;

endpackage

@@ hw/rtl/mbag_ram.sv @@
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
module mbag_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ hw/rtl/multiset_bag_table.sv @@
`timescale 1ns / 1ps
// Top level of the bag table: a fixed-capacity multiset of 32-bit values.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------
//   request | in        | in_valid / in_stall  | cmd [1:0], value [31:0]
//   result  | out       | out_valid / out_stall| ok, count [10:0]
//
// An insert goes from idle to the response state, which loads its result into the
// output register once that register is free. An erase scans the stored entries
// with one RAM read per entry; a removal of any but the last entry adds a read of
// the last entry, which fills the hole, before an erase-all scan picks up again.
// The scan and this fetch share the single read port of the entry RAM.
// Reset clears the occupancy and the control state at once; the entry RAM is
// never cleared, since a slot is only read after it has been written.
// A stalled result sits in the output register while the next request is
// taken; that request's result then waits until the register is free.
module multiset_bag_table
	import mbag_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [CMD_W-1:0]          cmd,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      ok,
	output logic [COUNT_W-1:0]        count
);

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_MOVE = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

	state_t               state_q, state_d;
	cmd_t                 cmd_q, cmd_d;
	logic [VALUE_W-1:0]   val_q, val_d;
	logic [OCC_W-1:0]     occ_q, occ_d;
	logic [OCC_W-1:0]     occ_dec;
	logic [OCC_W-1:0]     rd_ptr_q, rd_ptr_d;
	logic                 pend_s1, pend_d;
	logic [ADDR_W-1:0]    pend_idx_s1, pend_idx_d;
	logic [ADDR_W-1:0]    match_q, match_d;
	logic                 hit_q, hit_d;
	logic                 out_valid_q, out_valid_d;
	logic                 ok_q, ok_d;
	logic [COUNT_W-1:0]   count_q, count_d;

	logic                 in_accept;
	logic                 rd_hit;
	logic                 ram_wr_en;
	logic [ADDR_W-1:0]    ram_wr_addr;
	logic [VALUE_W-1:0]   ram_wr_data;
	logic                 ram_rd_en;
	logic [ADDR_W-1:0]    ram_rd_addr;
	logic [VALUE_W-1:0]   ram_rd_data;

	// The entries live in a single RAM; the scan and the move of the last
	// entry share its read port.
	mbag_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (BAG_DEPTH)
	) u_entries (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// One request at a time: the block is only open while the sequencer idles.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign occ_dec = occ_q - 1'b1;
	assign rd_hit  = (ram_rd_data == val_q);

	always_comb begin
		state_d     = state_q;
		cmd_d       = cmd_q;
		val_d       = val_q;
		occ_d       = occ_q;
		rd_ptr_d    = rd_ptr_q;
		pend_d      = pend_s1;
		pend_idx_d  = pend_idx_s1;
		match_d     = match_q;
		hit_d       = hit_q;
		ok_d        = ok_q;
		count_d     = count_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = ram_rd_data;
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;

		// The output register empties on a transfer unless it is reloaded below.
		out_valid_d = out_valid_q && out_stall;

		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					cmd_d    = cmd_t'(cmd);
					val_d    = value;
					hit_d    = 1'b0;
					rd_ptr_d = '0;
					pend_d   = 1'b0;
					unique case (cmd_t'(cmd))
						CMD_INSERT: begin
							// Append at the end of the packed region when there is room.
							if (occ_q < OCC_W'(BAG_DEPTH)) begin
								ram_wr_en   = 1'b1;
								ram_wr_addr = occ_q[ADDR_W-1:0];
								ram_wr_data = value;
								occ_d       = occ_q + 1'b1;
								hit_d       = 1'b1;
							end
							state_d = ST_RESP;
						end
						CMD_ERASE_ONE, CMD_ERASE_ALL: begin
							state_d = ST_SCAN;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end

			ST_SCAN: begin
				// One read per cycle until a match; its data is compared next cycle.
				if (pend_s1 && rd_hit) begin
					hit_d   = 1'b1;
					occ_d   = occ_dec;
					match_d = pend_idx_s1;
					pend_d  = 1'b0;
					if (OCC_W'(pend_idx_s1) < occ_dec) begin
						// Fetch the last entry so that it can fill the hole.
						ram_rd_en   = 1'b1;
						ram_rd_addr = occ_dec[ADDR_W-1:0];
						state_d     = ST_MOVE;
					end else begin
						// The match was the last entry, so dropping the count is enough.
						state_d = ST_RESP;
					end
				end else if (rd_ptr_q < occ_q) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = rd_ptr_q[ADDR_W-1:0];
					pend_d      = 1'b1;
					pend_idx_d  = rd_ptr_q[ADDR_W-1:0];
					rd_ptr_d    = rd_ptr_q + 1'b1;
				end else begin
					pend_d  = 1'b0;
					state_d = ST_RESP;
				end
			end

			ST_MOVE: begin
				// The last entry has arrived; it takes the place of the match.
				ram_wr_en   = 1'b1;
				ram_wr_addr = match_q;
				ram_wr_data = ram_rd_data;
				if (cmd_q == CMD_ERASE_ALL) begin
					if (rd_hit) begin
						// The moved entry matches as well, so remove it from the same slot.
						occ_d = occ_dec;
						if (OCC_W'(match_q) < occ_dec) begin
							ram_rd_en   = 1'b1;
							ram_rd_addr = occ_dec[ADDR_W-1:0];
						end else begin
							state_d = ST_RESP;
						end
					end else begin
						rd_ptr_d = OCC_W'(match_q) + 1'b1;
						pend_d   = 1'b0;
						state_d  = ST_SCAN;
					end
				end else begin
					state_d = ST_RESP;
				end
			end

			ST_RESP: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d = 1'b1;
					ok_d        = hit_q;
					count_d     = COUNT_W'(occ_q);
					state_d     = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			pend_s1     <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			occ_q       <= occ_d;
			pend_s1     <= pend_d;
			hit_q       <= hit_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q       <= cmd_d;
		val_q       <= val_d;
		rd_ptr_q    <= rd_ptr_d;
		pend_idx_s1 <= pend_idx_d;
		match_q     <= match_d;
		ok_q        <= ok_d;
		count_q     <= count_d;
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign count     = count_q;

endmodule

@@ hw/rtl/mbag_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the bag table, bound to the top level.
module mbag_checker
	import mbag_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic               ok,
	input logic [COUNT_W-1:0] count
);

	// Count shown by the most recent result transfer.
	logic [COUNT_W-1:0] last_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_count_q <= '0;
		end else if (out_valid && !out_stall) begin
			last_count_q <= count;
		end
	end

	in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid)
		else $error("request withdrawn while stalled");

	out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ok) && $stable(count))
		else $error("result changed while stalled");

	busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken before the first finished");

	fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> count == last_count_q)
		else $error("failed request changed the count");

	ok_moves_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ok |-> (BAG_DEPTH > 2047) || (count != last_count_q))
		else $error("successful request left the count unchanged");

endmodule

bind multiset_bag_table mbag_checker u_mbag_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the bag table: directed, capacity, backlog and random request tests.
module testbench
	import mbag_pkg::*;
();

	// The command field has one code that the package leaves unnamed; the block must
	// still answer it, with ok low and the occupancy unchanged.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	localparam int  CLK_PERIOD      = 20;
	localparam int  RESET_CYCLES    = 10;
	localparam int  RANDOM_ITEMS    = 580;
	localparam int  POOL_SIZE       = 8;
	// An erase over a full store with every entry removed costs at most about two passes;
	// this leaves a wide margin on top of that.
	localparam int  DRAIN_CYCLES    = 3 * BAG_DEPTH + 100;
	localparam int  BACKLOG_CYCLES  = 300;
	localparam int  LIMIT_CYCLES    = 1_500_000;

	typedef struct packed {
		logic               ok;
		logic [COUNT_W-1:0] count;
	} bag_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [CMD_W-1:0]          cmd;
	logic signed [VALUE_W-1:0] value;
	logic                      out_valid;
	logic                      out_stall;
	logic                      ok;
	logic [COUNT_W-1:0]        count;

	// Shadow copy of the bag, updated at every request transfer.
	logic [VALUE_W-1:0] bag_store [BAG_DEPTH];
	int unsigned        bag_fill;

	bag_result_t awaited_results [$];
	int          error_count;
	int          results_seen;
	int          refusals;
	int          peak_fill;
	int          op_tally [4];

	bit                 hold_request;
	bit                 burst_mode;
	logic [VALUE_W-1:0] value_pool [POOL_SIZE];

	multiset_bag_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ok        (ok),
		.count     (count)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Work out what one request does to the shadow bag and what the block should answer.
	// A removal always moves the last entry into the freed slot, so erase-all has to look
	// at the same slot again before moving on.
	function automatic bag_result_t predict_bag_op(input logic [CMD_W-1:0] op,
			input logic [VALUE_W-1:0] operand);
		bag_result_t res;
		int unsigned idx;
		int unsigned held_before;
		bit          hit;
		res.ok = 1'b0;
		idx = 0;
		hit = 1'b0;
		held_before = bag_fill;
		case (op)
			CMD_INSERT: begin
				if (bag_fill < BAG_DEPTH) begin
					bag_store[bag_fill] = operand;
					bag_fill++;
					res.ok = 1'b1;
				end
			end
			CMD_ERASE_ONE: begin
				while (!hit && idx < bag_fill) begin
					if (bag_store[idx] == operand) begin
						bag_fill--;
						bag_store[idx] = bag_store[bag_fill];
						hit = 1'b1;
					end else begin
						idx++;
					end
				end
				res.ok = hit;
			end
			CMD_ERASE_ALL: begin
				while (idx < bag_fill) begin
					if (bag_store[idx] == operand) begin
						bag_fill--;
						bag_store[idx] = bag_store[bag_fill];
					end else begin
						idx++;
					end
				end
				res.ok = (bag_fill < held_before);
			end
			default: begin
				// The unused code leaves the bag alone.
			end
		endcase
		res.count = bag_fill[COUNT_W-1:0];
		return res;
	endfunction

	// Request side: every transfer is predicted at the edge that accepts it.
	always @(posedge clk) begin
		bag_result_t want;
		if (arst_n && in_valid && !in_stall) begin
			want = predict_bag_op(cmd, value);
			awaited_results.push_back(want);
			op_tally[cmd]++;
			if (!want.ok)
				refusals++;
			if (int'(bag_fill) > peak_fill)
				peak_fill = bag_fill;
		end
	end

	// Result side: each transfer is matched against the oldest outstanding prediction.
	always @(posedge clk) begin
		bag_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				error_count++;
				$display("%0t: result with nothing outstanding: ok=%0b count=%0d",
					$time, ok, count);
			end else begin
				want = awaited_results.pop_front();
				if (ok !== want.ok) begin
					error_count++;
					$display("%0t: ok expected %0b, actual %0b", $time, want.ok, ok);
				end
				if (count !== want.count) begin
					error_count++;
					$display("%0t: count expected %0d, actual %0d", $time, want.count, count);
				end
			end
		end
	end

	// Result back-pressure. It runs in segments of quiet, light and heavy stalling, and
	// on request holds off for a long, fixed stretch so that the block backs up.
	initial begin : result_backpressure
		int seg_left;
		int seg_mode;
		out_stall = 1'b0;
		seg_left = 0;
		seg_mode = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_stall <= 1'b1;
				repeat (BACKLOG_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(20, 200);
					seg_mode = $urandom_range(0, 2);
				end
				seg_left--;
				case (seg_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 9) < 3);
					default: begin
						if ($urandom_range(0, 19) == 0) begin
							out_stall <= 1'b1;
							repeat ($urandom_range(10, 40)) @(negedge clk);
							out_stall <= 1'b0;
						end else begin
							out_stall <= ($urandom_range(0, 1) == 0);
						end
					end
				endcase
			end
		end
	end

	// Idle cycles ahead of a request: mostly none or a few, now and then a long pause.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (burst_mode || roll < 55)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Present one request at a falling edge and hold it until it is accepted. The valid
	// is only lowered when there is a gap, so it is never dropped and raised in one step.
	task automatic send_request(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] operand,
			input int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		value    <= operand;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Stop offering requests and wait for every outstanding result to come back.
	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// Empty bag, the extreme values, every command, a miss, a hit on the last slot, and
	// an erase-all where the entry moved into the freed slot matches as well.
	task automatic test_directed_cases();
		send_request(CMD_ERASE_ONE, 32'h0000_0005, 0);
		send_request(CMD_ERASE_ALL, 32'h0000_0005, 0);
		send_request(CMD_UNUSED, 32'h0000_0000, 0);
		send_request(CMD_INSERT, 32'h8000_0000, 0);
		send_request(CMD_INSERT, 32'h7FFF_FFFF, 0);
		send_request(CMD_INSERT, 32'h0000_0000, 1);
		send_request(CMD_INSERT, 32'hFFFF_FFFF, 0);
		send_request(CMD_INSERT, 32'h7FFF_FFFF, 0);
		send_request(CMD_INSERT, 32'h7FFF_FFFF, 2);
		send_request(CMD_ERASE_ONE, 32'h7FFF_FFFF, 0);
		send_request(CMD_ERASE_ALL, 32'h7FFF_FFFF, 0);
		send_request(CMD_ERASE_ONE, 32'h0000_0001, 0);
		send_request(CMD_UNUSED, 32'h7FFF_FFFF, 0);
		send_request(CMD_ERASE_ALL, 32'h8000_0000, 0);
		send_request(CMD_ERASE_ONE, 32'hFFFF_FFFF, 0);
		send_request(CMD_ERASE_ONE, 32'h0000_0000, 0);
		// Same low bits, different sign bit: must not match.
		send_request(CMD_INSERT, 32'h0000_0001, 0);
		send_request(CMD_ERASE_ONE, 32'h8000_0001, 0);
		send_request(CMD_ERASE_ALL, 32'h0000_0001, 0);
		send_request(CMD_INSERT, 32'hFFFF_FFFF, 0);
		send_request(CMD_INSERT, 32'hFFFF_FFFF, 0);
		send_request(CMD_INSERT, 32'hFFFF_FFFF, 0);
		send_request(CMD_ERASE_ALL, 32'hFFFF_FFFF, 0);
	endtask

	// Fill the store to capacity from a few values, push against the limit, then empty it
	// again with erase-all and a last erase-one; each erase-all has to walk the whole store.
	task automatic test_full_bag();
		int                 needed;
		logic [VALUE_W-1:0] absent;
		wait_results_drained();
		for (int k = 0; k < 6; k++)
			value_pool[k] = $urandom();
		needed = BAG_DEPTH - bag_fill;
		for (int k = 0; k < needed; k++)
			send_request(CMD_INSERT, value_pool[$urandom_range(0, 5)], pick_gap());
		send_request(CMD_INSERT, $urandom(), 0);
		send_request(CMD_INSERT, value_pool[0], 0);
		send_request(CMD_UNUSED, value_pool[1], pick_gap());
		absent = $urandom();
		while (absent == value_pool[0] || absent == value_pool[1] || absent == value_pool[2] ||
				absent == value_pool[3] || absent == value_pool[4] || absent == value_pool[5])
			absent = $urandom();
		send_request(CMD_ERASE_ONE, absent, 0);
		send_request(CMD_ERASE_ALL, absent, 0);
		send_request(CMD_ERASE_ONE, value_pool[2], 0);
		send_request(CMD_INSERT, absent, 0);
		send_request(CMD_INSERT, absent, 0);
		for (int k = 0; k < 6; k++)
			send_request(CMD_ERASE_ALL, value_pool[k], pick_gap());
		send_request(CMD_ERASE_ONE, absent, 0);
		send_request(CMD_ERASE_ONE, absent, 0);
	endtask

	// Hold the result side off while requests keep coming, so the output register and the
	// request behind it fill and the block has to stall its input.
	task automatic test_output_backlog();
		hold_request = 1'b1;
		for (int k = 0; k < 12; k++)
			send_request(CMD_INSERT, 32'h1234_0000 + k, 0);
		send_request(CMD_ERASE_ONE, 32'h1234_0003, 0);
		send_request(CMD_ERASE_ALL, 32'h1234_0005, 0);
		send_request(CMD_UNUSED, 32'h1234_0000, 0);
		for (int k = 0; k < 12; k++)
			send_request(CMD_ERASE_ALL, 32'h1234_0000 + k, 0);
	endtask

	// Random traffic drawn mostly from a small pool so that erases find their targets.
	// The command mix leans towards erasing as the bag grows, which keeps the scans short.
	task automatic test_random_traffic();
		logic [CMD_W-1:0]   op;
		logic [VALUE_W-1:0] operand;
		int                 roll;
		int unsigned        held;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				for (int k = 0; k < POOL_SIZE; k++)
					value_pool[k] = $urandom();
				value_pool[0] = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end
			if (n % 40 == 0)
				burst_mode = ($urandom_range(0, 3) == 0);
			held = bag_fill;
			roll = $urandom_range(0, 99);
			if (roll < 5)
				op = CMD_UNUSED;
			else if (held > 40)
				op = (roll < 30) ? CMD_INSERT : (roll < 60) ? CMD_ERASE_ONE : CMD_ERASE_ALL;
			else
				op = (roll < 60) ? CMD_INSERT : (roll < 85) ? CMD_ERASE_ONE : CMD_ERASE_ALL;
			roll = $urandom_range(0, 99);
			if (roll < 20)
				operand = $urandom();
			else if (roll < 40 && held > 0 && op != CMD_INSERT)
				operand = bag_store[$urandom_range(0, held - 1)];
			else
				operand = value_pool[$urandom_range(0, POOL_SIZE - 1)];
			send_request(op, operand, pick_gap());
		end
		burst_mode = 1'b0;
	endtask

	initial begin : run_tests
		in_valid     = 1'b0;
		cmd          = CMD_INSERT;
		value        = '0;
		arst_n       = 1'b0;
		hold_request = 1'b0;
		burst_mode   = 1'b0;
		bag_fill     = 0;
		error_count  = 0;
		results_seen = 0;
		refusals     = 0;
		peak_fill    = 0;
		for (int k = 0; k < 4; k++)
			op_tally[k] = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_full_bag();
		test_output_backlog();
		test_random_traffic();

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Requests sent: %0d inserts, %0d erase-one, %0d erase-all, %0d unused code.",
			op_tally[CMD_INSERT], op_tally[CMD_ERASE_ONE], op_tally[CMD_ERASE_ALL],
			op_tally[CMD_UNUSED]);
		$display("Results checked: %0d, of which %0d refused; largest occupancy %0d of %0d.",
			results_seen, refusals, peak_fill, BAG_DEPTH);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin : watchdog
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("Run timed out with %0d results outstanding.", awaited_results.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
